[hdl/tcw_pkg.sv]
// shared types and constants of the text console writer
// no dependencies
package tcw_pkg;

  // input field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ADDR_W = 11;

  // result field widths
  localparam int CELL_W = 16;
  localparam int OCOL_W = 7;
  localparam int OROW_W = 5;
  localparam int OLOC_W = 11;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // honored control bytes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // white-on-black space
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_DIV,
    ST_RDATA,
    ST_DONE
  } tcw_state_t;

endpackage

[hdl/text_console_writer_unit.sv]
// text console writer: cell store, cursor and command sequencer
// depends on tcw_pkg
//
// sequence: write, clear, unused command and out-of-range read pass ST_EXEC and ST_DONE
// from accept to out_tvalid, after an ST_FILL pass that blanks the row when a printable byte
// lands on a still-blank row; an in-range read adds ST_DIV (repeated subtract) and ST_RDATA
// throughput: one item at a time; the next item is taken while the last result waits
// reset: cursor home, ring offset zero, every row marked blank so the whole store reads
// 0x0F20 at once; no clearing pass over the memory
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // character[7:0], attribute[15:8], cell_address[26:16]
  input  logic [CMD_W-1:0]       in_tuser,   // command[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // cell_data[15:0], cursor_column[22:16],
                                             // cursor_row[27:23], cursor_index[38:28]
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CXW   = $clog2(COLUMNS + TAB_STOP);
  localparam int RW    = $clog2(ROWS);
  localparam int RXW   = $clog2(ROWS + 1);
  localparam int PW    = $clog2(TAB_STOP);

  // logical row plus ring offset, folded back into the store
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] top);
    logic [RW:0] s;
    s = {1'b0, lrow} + {1'b0, top};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
    return AW'(prow) * AW'(COLUMNS) + AW'(col);
  endfunction

  // control state
  tcw_state_t state_r, state_nxt;
  logic [CW-1:0]   col_r;
  logic [RW-1:0]   row_r;
  logic [PW-1:0]   phase_r;      // cursor column modulo tab stop
  logic [RW-1:0]   top_r;        // physical row shown as logical row 0
  logic [ROWS-1:0] row_valid_r;  // physical row holds written data, else reads blank
  logic [CW-1:0]   fill_cnt_r;
  logic            out_valid_r;

  // item payload
  logic [CMD_W-1:0]     cmd_r;
  logic [CHAR_W-1:0]    ch_r;
  logic [ATTR_W-1:0]    attr_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [ADDR_W-1:0]    rem_r;
  logic [RW-1:0]        quo_r;
  logic                 rd_valid_r;
  logic [CELL_W-1:0]    data_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // cell store
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] mem_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  // combinational helpers
  logic            printable;
  logic [RW-1:0]   cur_prow;
  logic [RW-1:0]   rd_prow;
  logic            need_fill;
  logic            div_done;
  logic            addr_ok;
  logic            out_load;
  logic [CXW-1:0]  col_x;
  logic [RXW-1:0]  row_x;
  logic [PW-1:0]   phase_nxt;
  logic            scroll;
  logic [AW-1:0]   loc;

  assign printable = (ch_r >= CH_SPACE) && !ch_r[CHAR_W-1];
  assign cur_prow  = phys_row(row_r, top_r);
  assign rd_prow   = phys_row(quo_r, top_r);
  assign need_fill = (cmd_r == CMD_WRITE) && printable && !row_valid_r[cur_prow];
  assign div_done  = rem_r < ADDR_W'(COLUMNS);
  assign addr_ok   = 32'(addr_r) < CELLS;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign loc       = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // cursor step for a write command
  always_comb begin
    col_x     = CXW'(col_r);
    row_x     = RXW'(row_r);
    phase_nxt = phase_r;
    scroll    = 1'b0;
    case (ch_r)
      CH_BS: begin
        if (col_r != '0) begin
          col_x     = col_x - CXW'(1);
          phase_nxt = (phase_r == '0) ? PW'(TAB_STOP - 1) : phase_r - PW'(1);
        end
      end
      CH_TAB: begin
        col_x     = col_x + CXW'(TAB_STOP) - CXW'(phase_r);
        phase_nxt = '0;
      end
      CH_CR: begin
        col_x     = '0;
        phase_nxt = '0;
      end
      CH_LF: begin
        col_x     = '0;
        row_x     = row_x + RXW'(1);
        phase_nxt = '0;
      end
      default: begin
        if (printable) begin
          col_x     = col_x + CXW'(1);
          phase_nxt = (phase_r == PW'(TAB_STOP - 1)) ? '0 : phase_r + PW'(1);
        end
      end
    endcase
    // wrap past the last column
    if (col_x >= CXW'(COLUMNS)) begin
      col_x     = '0;
      row_x     = row_x + RXW'(1);
      phase_nxt = '0;
    end
    // scroll past the last row: advance the ring, bottom row goes blank
    if (row_x >= RXW'(ROWS)) begin
      row_x  = RXW'(ROWS - 1);
      scroll = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (need_fill) begin
          state_nxt = ST_FILL;
        end else if (cmd_r == CMD_READ && addr_ok) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FILL: begin
        if (fill_cnt_r == CW'(COLUMNS - 1)) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RDATA;
        end
      end
      ST_RDATA: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(cur_prow, col_r);
    mem_wdata = {attr_r, ch_r};
    mem_re    = 1'b0;
    mem_raddr = cell_addr(rd_prow, rem_r[CW-1:0]);
    case (state_r)
      ST_EXEC: begin
        mem_we = (cmd_r == CMD_WRITE) && printable && !need_fill;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(cur_prow, fill_cnt_r);
        mem_wdata = BLANK_CELL;
      end
      ST_DIV: begin
        mem_re = div_done;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      phase_r     <= '0;
      top_r       <= '0;
      row_valid_r <= '0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_EXEC: begin
          fill_cnt_r <= '0;
          if (cmd_r == CMD_CLEAR) begin
            col_r       <= '0;
            row_r       <= '0;
            phase_r     <= '0;
            top_r       <= '0;
            row_valid_r <= '0;
          end else if (cmd_r == CMD_WRITE && !need_fill) begin
            col_r   <= col_x[CW-1:0];
            row_r   <= row_x[RW-1:0];
            phase_r <= phase_nxt;
            if (scroll) begin
              row_valid_r[top_r] <= 1'b0;
              top_r <= (top_r == RW'(ROWS - 1)) ? '0 : top_r + RW'(1);
            end
          end
        end
        ST_FILL: begin
          fill_cnt_r <= fill_cnt_r + CW'(1);
          if (fill_cnt_r == CW'(COLUMNS - 1)) begin
            row_valid_r[cur_prow] <= 1'b1;
          end
        end
        default: begin
          fill_cnt_r <= '0;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      ch_r   <= in_tdata[7:0];
      attr_r <= in_tdata[15:8];
      addr_r <= in_tdata[26:16];
    end
    case (state_r)
      ST_EXEC: begin
        data_r <= '0;
        rem_r  <= addr_r;
        quo_r  <= '0;
      end
      ST_DIV: begin
        if (div_done) begin
          rd_valid_r <= row_valid_r[rd_prow];
        end else begin
          rem_r <= rem_r - ADDR_W'(COLUMNS);
          quo_r <= quo_r + RW'(1);
        end
      end
      ST_RDATA: begin
        data_r <= rd_valid_r ? mem_q : BLANK_CELL;
      end
      default: begin
        data_r <= data_r;
      end
    endcase
    if (out_load) begin
      out_data_r <= {1'b0, OLOC_W'(loc), OROW_W'(row_r), OCOL_W'(col_r), data_r};
    end
  end

endmodule

[hdl/tcw_checker.sv]
// port-level checks for the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer_unit
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // no result comes out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // reported cursor always inside the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[22:16]) < COLUMNS) && (32'(out_tdata[27:23]) < ROWS))
    else $error("cursor outside the screen");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (.*);

[dv/text_console_writer_unit_tb.sv]
// self-checking testbench for text_console_writer_unit: directed table, then random items
// depends on tcw_pkg and the text_console_writer_unit rtl; a console model here predicts results
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam int COLS      = 80;
  localparam int LINES     = 25;
  localparam int TAB_W     = 8;
  localparam int CELLS     = COLS * LINES;
  localparam int N_ITEMS   = 1650;
  localparam int N_QUIET   = 200;    // tail of the run with no idling on either side
  localparam int HOLD_AT   = 600;    // item count at which the receiver holds off
  localparam int HOLD_LEN  = 400;    // cycles of that hold-off
  localparam int WDOG_MAX  = 5000;   // cycles with no handshake before giving up
  localparam int TAIL_WAIT = 120;

  // the one command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic [OLOC_W-1:0] loc;
  } console_result_t;

  // one row of the directed table; known marks rows whose result is typed in
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [ADDR_W-1:0] addr;
    logic              known;
    console_result_t   res;
  } console_stim_t;

  localparam console_result_t NO_RES  = '{cell_data: 16'h0, col: 7'd0, row: 5'd0, loc: 11'd0};
  localparam console_result_t HOME_BL = '{cell_data: BLANK_CELL, col: 7'd0, row: 5'd0,
                                          loc: 11'd0};

  localparam int N_DIRECTED = 23;
  localparam console_stim_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{CMD_READ,   8'h00,  8'h00, 11'd0,    1'b1, HOME_BL},  // fresh store reads blank
    '{CMD_READ,   8'hFF,  8'hFF, 11'd1999, 1'b1, HOME_BL},  // last cell
    '{CMD_READ,   8'h00,  8'h00, 11'h7FF,  1'b1, NO_RES},   // address past the store
    '{CMD_UNUSED, 8'hFF,  8'hFF, 11'h7FF,  1'b1, NO_RES},   // unused command: nothing moves
    '{CMD_WRITE,  CH_BS,  8'h00, 11'd0,    1'b1, NO_RES},   // backspace at column zero
    '{CMD_WRITE,  8'h41,  8'hFF, 11'd0,    1'b0, NO_RES},
    '{CMD_WRITE,  8'h7F,  8'h00, 11'd0,    1'b0, NO_RES},   // highest printable byte
    '{CMD_WRITE,  8'h20,  8'h5A, 11'd0,    1'b0, NO_RES},   // lowest printable byte
    '{CMD_READ,   8'h00,  8'h00, 11'd0,    1'b0, NO_RES},
    '{CMD_READ,   8'h00,  8'h00, 11'd1,    1'b0, NO_RES},
    '{CMD_WRITE,  CH_BS,  8'h00, 11'd0,    1'b0, NO_RES},
    '{CMD_WRITE,  CH_TAB, 8'h00, 11'd0,    1'b0, NO_RES},
    '{CMD_WRITE,  8'h00,  8'h00, 11'd0,    1'b0, NO_RES},   // non-printing low bytes
    '{CMD_WRITE,  8'h1F,  8'hFF, 11'd0,    1'b0, NO_RES},
    '{CMD_WRITE,  8'h80,  8'h0F, 11'd0,    1'b0, NO_RES},   // negative as signed char
    '{CMD_WRITE,  8'hFF,  8'hFF, 11'd0,    1'b0, NO_RES},
    '{CMD_WRITE,  CH_CR,  8'h00, 11'd0,    1'b0, NO_RES},
    '{CMD_WRITE,  CH_LF,  8'h00, 11'd0,    1'b0, NO_RES},
    '{CMD_WRITE,  CH_LF,  8'h00, 11'd0,    1'b0, NO_RES},
    '{CMD_READ,   8'h00,  8'h00, 11'd2,    1'b0, NO_RES},
    '{CMD_CLEAR,  8'h00,  8'h00, 11'd0,    1'b1, NO_RES},   // clear homes the cursor
    '{CMD_READ,   8'h00,  8'h00, 11'd0,    1'b1, HOME_BL},
    '{CMD_READ,   8'h00,  8'h00, 11'd2,    1'b1, HOME_BL}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // character[7:0], attribute[15:8], cell_address[26:16]
  logic [CMD_W-1:0]       in_tuser;   // command[1:0]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // cell_data[15:0], cursor_column[22:16],
                                      // cursor_row[27:23], cursor_index[38:28]

  // console model state
  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;

  console_result_t   pending_results[$];
  int                error_count;
  int                items_sent;
  bit                quiet;      // no idling in the final stretch
  bit                hold_req;   // asks the receiver for its long hold-off
  int                stall_cycles;

  text_console_writer_unit #(
    .COLUMNS (COLS),
    .ROWS    (LINES),
    .TAB_STOP(TAB_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // console model: applies one command and returns the result it reports
  function automatic console_result_t predict_console(input logic [CMD_W-1:0] cmd,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [ATTR_W-1:0] attr,
                                                      input logic [ADDR_W-1:0] addr);
    console_result_t r;
    r.cell_data = '0;
    case (cmd)
      CMD_WRITE: begin
        if (ch == CH_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (ch == CH_TAB) begin
          cur_col = cur_col + TAB_W - (cur_col % TAB_W);
        end else if (ch == CH_CR) begin
          cur_col = 0;
        end else if (ch == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (ch >= CH_SPACE && !ch[7]) begin
          // printable: store with attribute, then step right
          screen_model[cur_row * COLS + cur_col] = {attr, ch};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        // off the bottom: everything moves up a row, bottom row goes blank
        if (cur_row >= LINES) begin
          for (int i = 0; i < (LINES - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (int i = (LINES - 1) * COLS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
          cur_row = LINES - 1;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ: begin
        if (addr < CELLS) r.cell_data = screen_model[addr];
      end
      default: ;
    endcase
    r.col = cur_col[OCOL_W-1:0];
    r.row = cur_row[OROW_W-1:0];
    r.loc = OLOC_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // offers one item and holds it until the block takes it; known rows queue the typed result
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [ATTR_W-1:0] attr, input logic [ADDR_W-1:0] addr,
                           input logic known, input console_result_t typed);
    console_result_t predicted;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, addr, attr, ch};
    do @(posedge clk); while (!in_tready);
    predicted = predict_console(cmd, ch, attr, addr);
    pending_results.push_back(known ? typed : predicted);
    items_sent++;
    if (items_sent == HOLD_AT) hold_req = 1'b1;
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // random item, biased toward printing and line feeds so the store fills and scrolls
  task automatic send_random_item();
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [ADDR_W-1:0] addr;
    int                pick;
    cmd  = CMD_WRITE;
    ch   = 8'($urandom_range(32, 127));
    attr = 8'($urandom);
    addr = 11'($urandom);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 299) == 0) begin
      cmd = CMD_CLEAR;
    end else if (pick < 45) begin
      cmd = CMD_WRITE;
    end else if (pick < 55) begin
      ch = CH_LF;
    end else if (pick < 60) begin
      ch = CH_TAB;
    end else if (pick < 63) begin
      ch = CH_CR;
    end else if (pick < 67) begin
      ch = CH_BS;
    end else if (pick < 71) begin
      // non-printing: control range or high half
      ch = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(128, 255));
    end else if (pick < 98) begin
      cmd = CMD_READ;
      // four in ten of the reads look in the cursor row, where the writes land
      case ($urandom_range(0, 9))
        0:       addr = 11'($urandom_range(CELLS, 2047));
        1, 2, 3,
        4:       addr = 11'(cur_row * COLS + $urandom_range(0, COLS - 1));
        default: addr = 11'($urandom_range(0, CELLS - 1));
      endcase
    end else begin
      cmd = CMD_UNUSED;
    end
    send_item(cmd, ch, attr, addr, 1'b0, NO_RES);
  endtask

  // stimulus
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_WRITE;
    error_count  = 0;
    items_sent   = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    cur_col      = 0;
    cur_row      = 0;
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].attr,
                DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].res);
      if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 12));
    end

    // random part; idle bursts only in two out of every three stretches of 60 items
    for (int i = N_DIRECTED; i < N_ITEMS; i++) begin
      if (i >= N_ITEMS - N_QUIET) quiet = 1'b1;
      send_random_item();
      if (!quiet && ((i / 60) % 3 != 0) && $urandom_range(0, 3) == 0)
        sender_gap($urandom_range(1, 12));
    end
    sender_gap(1);

    // drain, then give the block time to show any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("text_console_writer_unit_tb: clean");
    end else begin
      $display("text_console_writer_unit_tb: errors");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold-off while the sender keeps offering
  initial begin
    int  left;
    bit  held;
    out_tready = 1'b0;
    left       = 0;
    held       = 1'b0;
    stall_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall_cycles++;
      if (hold_req && !held) begin
        held = 1'b1;
        left = HOLD_LEN;
      end
      if (left > 0) begin
        left--;
        out_tready <= 1'b0;
      end else if (!quiet && ((stall_cycles / 400) % 3 != 0) && $urandom_range(0, 7) == 0) begin
        left = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker: each taken item against the oldest prediction, field by field
  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result item 0x%0h at %0t", out_tdata, $realtime);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[15:0] !== want.cell_data)
          report_mismatch("cell_data", out_tdata[15:0], want.cell_data);
        if (out_tdata[22:16] !== want.col)
          report_mismatch("cursor_column", out_tdata[22:16], want.col);
        if (out_tdata[27:23] !== want.row)
          report_mismatch("cursor_row", out_tdata[27:23], want.row);
        if (out_tdata[38:28] !== want.loc)
          report_mismatch("cursor_index", out_tdata[38:28], want.loc);
      end
    end
  end

  // watchdog: too long with no handshake on either side ends the run
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("timeout: no item moved for %0d cycles", WDOG_MAX);
        $display("text_console_writer_unit_tb: errors");
        $finish;
      end
    end
  end

endmodule
